FILE: hw/rtl/erg_pkg.sv
`timescale 1ns / 1ps

package erg_pkg;

    // Pattern word and the narrow counters that index into it
    localparam int PAT_W = 64;
    localparam int CNT_W = 7;

    typedef logic [PAT_W-1:0] t_pat;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [2:0]       t_state;

    // Ones in the low count bits; a count of PAT_W or more gives all ones
    function automatic t_pat low_ones(input t_cnt count);
        t_pat ones;
        ones = '1;
        if (count >= t_cnt'(PAT_W)) begin
            return ones;
        end
        return ~(ones << count);
    endfunction

    // Mirror bit order (wiring only)
    function automatic t_pat bit_rev(input t_pat a);
        t_pat y;
        for (int i = 0; i < PAT_W; i++) begin
            y[i] = a[PAT_W-1-i];
        end
        return y;
    endfunction

endpackage

FILE: hw/rtl/euclidean_rhythm_generator_unit.sv
`timescale 1ns / 1ps

// Euclidean rhythm generator. A request carries a pulse count, a step count
// (saturated to MAX_STEPS) and a signed rotation; the block answers with one
// 64-bit pattern where bit i is step i, pulses spread as evenly as possible,
// rotated right by the rotation reduced modulo the step count, and all bits
// at or above the step count clear. Requests are handled one at a time: the
// input side is ready only while the sequencer is idle, but it takes a new
// request while the previous pattern still sits in the output register. All
// the work goes through one 64-bit left shifter under a small sequencer:
// first the pairing rounds, then the groups laid out end to end, where
// pairing rounds plus groups never exceed the step count, then the
// rotation reduced by repeated add or subtract of the step count, then
// the rotation itself (ST_ROTL, ST_ROTR), and last the hand-over of the
// pattern to the output register, which waits only while that register
// is still occupied. A zero count or a pulse count of at least the step
// count skips straight from acceptance to the hand-over. The input side
// is ready again in the cycle after the result is handed over.
module euclidean_rhythm_generator_unit #(
    parameter int MAX_STEPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [6:0]  i_pulses,
    input  logic [6:0]  i_steps,
    input  logic signed [7:0] i_rotation,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_pattern
);

    localparam erg_pkg::t_state ST_IDLE = 3'd0;
    localparam erg_pkg::t_state ST_PAIR = 3'd1;
    localparam erg_pkg::t_state ST_FLAT = 3'd2;
    localparam erg_pkg::t_state ST_MOD  = 3'd3;
    localparam erg_pkg::t_state ST_ROTL = 3'd4;
    localparam erg_pkg::t_state ST_ROTR = 3'd5;
    localparam erg_pkg::t_state ST_HOLD = 3'd6;

    localparam erg_pkg::t_cnt STEP_MAX = erg_pkg::t_cnt'(MAX_STEPS);

    // Sequencer and working registers
    erg_pkg::t_state r_state, n_state;
    erg_pkg::t_pat   r_grp_p, n_grp_p;   // pattern group bits
    erg_pkg::t_pat   r_grp_r, n_grp_r;   // remainder group bits, later rotate scratch
    erg_pkg::t_cnt   r_len_p, n_len_p;
    erg_pkg::t_cnt   r_len_r, n_len_r;
    erg_pkg::t_cnt   r_cnt_p, n_cnt_p;
    erg_pkg::t_cnt   r_cnt_r, n_cnt_r;
    erg_pkg::t_cnt   r_pos,   n_pos;
    erg_pkg::t_cnt   r_n,     n_n;
    logic signed [8:0] r_rot, n_rot;
    erg_pkg::t_pat   r_acc,   n_acc;

    // Output register
    logic            r_out_valid, n_out_valid;
    erg_pkg::t_pat   r_pattern,   n_pattern;

    // Shared shifter
    erg_pkg::t_pat   sh_a, sh_y;
    erg_pkg::t_cnt   sh_s;

    erg_pkg::t_cnt   steps_sat;
    erg_pkg::t_cnt   pairs;
    logic            in_take;
    logic signed [8:0] n_signed;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_take     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_pattern   = r_pattern;

    assign steps_sat = (i_steps > STEP_MAX) ? STEP_MAX : i_steps;
    assign pairs     = (r_cnt_p < r_cnt_r) ? r_cnt_p : r_cnt_r;
    assign n_signed  = $signed({2'b00, r_n});

    // Select operand and amount for the one shifter by phase
    always_comb begin
        sh_a = r_grp_r;
        sh_s = r_len_p;
        unique case (r_state)
            ST_PAIR: begin
                sh_a = r_grp_r;
                sh_s = r_len_p;
            end
            ST_FLAT: begin
                sh_a = (r_cnt_p != '0) ? r_grp_p : r_grp_r;
                sh_s = r_pos;
            end
            ST_ROTL: begin
                sh_a = r_acc;
                sh_s = r_rot[6:0];
            end
            ST_ROTR: begin
                // right shift done as a left shift of the mirrored word
                sh_a = erg_pkg::bit_rev(r_acc);
                sh_s = r_n - r_rot[6:0];
            end
            default: begin
                sh_a = r_grp_r;
                sh_s = r_len_p;
            end
        endcase
        sh_y = sh_a << sh_s;
    end

    always_comb begin
        n_state     = r_state;
        n_grp_p     = r_grp_p;
        n_grp_r     = r_grp_r;
        n_len_p     = r_len_p;
        n_len_r     = r_len_r;
        n_cnt_p     = r_cnt_p;
        n_cnt_r     = r_cnt_r;
        n_pos       = r_pos;
        n_n         = r_n;
        n_rot       = r_rot;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_pattern   = r_pattern;

        // Drop the held result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_n   = steps_sat;
                    n_rot = 9'(i_rotation);
                    if (i_pulses == '0 || steps_sat == '0) begin
                        n_acc   = '0;
                        n_state = ST_HOLD;
                    end else if (i_pulses >= steps_sat) begin
                        n_acc   = erg_pkg::low_ones(steps_sat);
                        n_state = ST_HOLD;
                    end else begin
                        n_grp_p = erg_pkg::t_pat'(1);
                        n_len_p = erg_pkg::t_cnt'(1);
                        n_cnt_p = i_pulses;
                        n_grp_r = '0;
                        n_len_r = erg_pkg::t_cnt'(1);
                        n_cnt_r = steps_sat - i_pulses;
                        n_acc   = '0;
                        n_pos   = '0;
                        n_state = ST_PAIR;
                    end
                end
            end
            ST_PAIR: begin
                // One pairing round per cycle until one remainder group at most
                if (r_cnt_r > erg_pkg::t_cnt'(1)) begin
                    if (r_cnt_p > r_cnt_r) begin
                        n_grp_r = r_grp_p;
                        n_len_r = r_len_p;
                        n_cnt_r = r_cnt_p - pairs;
                    end else begin
                        n_cnt_r = r_cnt_r - pairs;
                    end
                    n_grp_p = r_grp_p | sh_y;
                    n_len_p = r_len_p + r_len_r;
                    n_cnt_p = pairs;
                end else begin
                    n_state = ST_FLAT;
                end
            end
            ST_FLAT: begin
                // Lay out one group per cycle, pattern groups first
                if (r_cnt_p != '0) begin
                    n_acc   = r_acc | sh_y;
                    n_pos   = r_pos + r_len_p;
                    n_cnt_p = r_cnt_p - erg_pkg::t_cnt'(1);
                end else if (r_cnt_r != '0) begin
                    n_acc   = r_acc | sh_y;
                    n_pos   = r_pos + r_len_r;
                    n_cnt_r = r_cnt_r - erg_pkg::t_cnt'(1);
                end else begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                // Reduce rotation into 0..n-1 by repeated add or subtract
                if (r_rot < 0) begin
                    n_rot = r_rot + n_signed;
                end else if (r_rot >= n_signed) begin
                    n_rot = r_rot - n_signed;
                end else begin
                    n_state = ST_ROTL;
                end
            end
            ST_ROTL: begin
                n_grp_r = sh_y;
                n_state = ST_ROTR;
            end
            ST_ROTR: begin
                n_acc   = (r_grp_r | erg_pkg::bit_rev(sh_y)) & erg_pkg::low_ones(r_n);
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_pattern   = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_p   <= n_grp_p;
        r_grp_r   <= n_grp_r;
        r_len_p   <= n_len_p;
        r_len_r   <= n_len_r;
        r_cnt_p   <= n_cnt_p;
        r_cnt_r   <= n_cnt_r;
        r_pos     <= n_pos;
        r_n       <= n_n;
        r_rot     <= n_rot;
        r_acc     <= n_acc;
        r_pattern <= n_pattern;
    end

    // A request always moves the sequencer out of idle
    a_take_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state != ST_IDLE)
        else $error("sequencer stayed idle after a request");

    // Group layout never runs past the step count
    a_flat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLAT |-> r_pos <= r_n)
        else $error("group layout ran past the step count");

    // Rotation is fully reduced before the rotate
    a_rot_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROTL |-> (r_rot >= 0 && r_rot < n_signed))
        else $error("rotation not reduced modulo the step count");

    // Finished pattern has no bits at or above the step count
    a_pattern_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HOLD |-> (r_acc & ~erg_pkg::low_ones(r_n)) == '0)
        else $error("pattern has bits above the step count");

endmodule

FILE: bench/tb_euclidean_rhythm_generator_unit.sv
`timescale 1ns / 1ps

module tb_euclidean_rhythm_generator_unit;

    localparam int MAX_STEPS    = 64;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    // Cycles with no request or pattern moving before the run is declared hung.
    // The slowest request and the longest receiver hold (HOLD_CYCLES) both
    // fall well short of it, so this leaves a wide margin.
    localparam int STALL_LIMIT  = 3000;
    // Receiver hold used to back the block up into its input.
    localparam int HOLD_CYCLES  = 400;
    // Quiet time after the last pattern, to catch any stray extra result.
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 31;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [6:0]          i_pulses;
    logic [6:0]          i_steps;
    logic signed [7:0]   i_rotation;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [63:0]         o_pattern;

    // Patterns still owed by the block, oldest first
    erg_pkg::t_pat expected_patterns[$];

    int  mismatch_count;
    int  patterns_checked;
    int  stall_cycles;
    int  hold_requests;
    bit  tx_idle_en;
    bit  rx_idle_en;

    euclidean_rhythm_generator_unit #(
        .MAX_STEPS(MAX_STEPS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pulses   (i_pulses),
        .i_steps    (i_steps),
        .i_rotation (i_rotation),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_pattern  (o_pattern)
    );

    // Free-running clock, 10 ns period
    initial begin
        i_clk = 1'b0;
    end

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: spread k onsets over n steps by repeated pairing of the
    // pulse groups with the rest groups, lay the groups out end to end,
    // then rotate right by the rotation reduced into 0..n-1.
    // ------------------------------------------------------------------
    function automatic erg_pkg::t_pat spread_onsets(input logic [6:0] k_in,
                                                     input logic [6:0] n_in,
                                                     input logic signed [7:0] rot_in);
        erg_pkg::t_pat head_grp, tail_grp, joined, laid_out, rotated;
        int k, n, rot, head_len, tail_len, head_cnt, tail_cnt;
        int pairs, joined_len, pos, shift, src;
        k   = int'(k_in);
        n   = int'(n_in);
        rot = int'(rot_in);
        // Empty pattern when either count is zero
        if (k == 0 || n == 0) begin
            return '0;
        end
        // Clamp the step count to what the pattern word holds
        if (n > MAX_STEPS) begin
            n = MAX_STEPS;
        end
        // Every step a pulse: low n bits set, rotation is invisible
        if (k >= n) begin
            return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        end

        head_grp = 64'd1;
        head_len = 1;
        head_cnt = k;
        tail_grp = '0;
        tail_len = 1;
        tail_cnt = n - k;

        // Pair head groups with tail groups until one tail group at most remains
        while (tail_cnt > 1) begin
            pairs      = (head_cnt < tail_cnt) ? head_cnt : tail_cnt;
            joined     = head_grp | (tail_grp << head_len);
            joined_len = head_len + tail_len;
            if (head_cnt > tail_cnt) begin
                // Leftover head groups become the new tail
                tail_grp = head_grp;
                tail_len = head_len;
                tail_cnt = head_cnt - pairs;
            end else begin
                tail_cnt = tail_cnt - pairs;
            end
            head_grp = joined;
            head_len = joined_len;
            head_cnt = pairs;
        end

        // Lay out head groups, then tail groups, from bit 0 upward
        laid_out = '0;
        pos      = 0;
        for (int c = 0; c < head_cnt && pos + head_len <= 64; c++) begin
            laid_out |= head_grp << pos;
            pos += head_len;
        end
        for (int c = 0; c < tail_cnt && pos + tail_len <= 64; c++) begin
            laid_out |= tail_grp << pos;
            pos += tail_len;
        end

        // Reduce the rotation to a non-negative residue and rotate right
        shift   = ((rot % n) + n) % n;
        rotated = '0;
        for (int i = 0; i < n; i++) begin
            src = (i - shift + n) % n;
            rotated[i] = laid_out[src];
        end
        return rotated;
    endfunction

    // ------------------------------------------------------------------
    // Request side: optionally idle at random, then offer one request and
    // hold it until the block takes it. Entered and left at a falling edge,
    // with valid left high so a follow-on request can go out back to back.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [6:0] k, input logic [6:0] n,
                                input logic signed [7:0] rot);
        while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pulses   = k;
        i_steps    = n;
        i_rotation = rot;
        // Hold until the handshake completes at a rising edge
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        expected_patterns.push_back(spread_onsets(k, n, rot));
        @(negedge i_clk);
    endtask

    // Draw one request: mostly proper spreads with random content, the rest
    // degenerate counts, full-pulse patterns and raw 7-bit noise.
    task automatic send_random_request();
        logic [6:0]        k, n;
        logic signed [7:0] rot;
        int                sel;
        sel = $urandom_range(99);
        rot = 8'($urandom_range(255, 0));
        if (sel < 80) begin
            // Favor short patterns now and then to keep the run quick
            if ($urandom_range(3) == 0) begin
                n = 7'($urandom_range(16, 2));
            end else begin
                n = 7'($urandom_range(MAX_STEPS, 2));
            end
            k = 7'($urandom_range(int'(n) - 1, 1));
        end else if (sel < 88) begin
            // Zero pulses or zero steps
            if ($urandom_range(1) == 0) begin
                k = '0;
                n = 7'($urandom_range(127, 0));
            end else begin
                k = 7'($urandom_range(127, 0));
                n = '0;
            end
        end else if (sel < 94) begin
            // Pulses at or above the step count
            n = 7'($urandom_range(MAX_STEPS, 1));
            k = 7'($urandom_range(127, int'(n)));
        end else begin
            // Anything the fields allow, including saturated step counts
            k = 7'($urandom_range(127, 0));
            n = 7'($urandom_range(127, 0));
        end
        send_request(k, n, rot);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready at random, except during a requested hold, which
    // is counted here in cycles. Ready changes at the falling edge.
    // ------------------------------------------------------------------
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen   = 0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (rx_idle_en && $urandom_range(99) < IDLE_PCT) begin
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Compare each delivered pattern with the oldest one still owed
    always @(posedge i_clk) begin
        erg_pkg::t_pat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_patterns.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("[%0t] unexpected pattern %h with no request pending",
                             $realtime, o_pattern);
                end
            end else begin
                want = expected_patterns.pop_front();
                patterns_checked++;
                if (o_pattern !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] pattern mismatch: expected %h, got %h",
                                 $realtime, want, o_pattern);
                    end
                end
            end
        end
    end

    // Watchdog: give up when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero counts, saturated step counts, full patterns and rotation extremes
    task automatic test_degenerate_requests();
        send_request(7'd0,   7'd0,   8'sd0);
        send_request(7'd0,   7'd64,  8'sd5);
        send_request(7'd5,   7'd0,   -8'sd3);
        send_request(7'd1,   7'd1,   8'sd127);
        send_request(7'd64,  7'd64,  -8'sd128);
        send_request(7'd127, 7'd127, -8'sd1);
        send_request(7'd70,  7'd13,  8'sd9);
        send_request(7'd3,   7'd100, -8'sd7);
        send_request(7'd63,  7'd127, 8'sd1);
        send_request(7'd64,  7'd5,   8'sd0);
    endtask

    // Known spreads, both pairing branches, negative and wrapping rotations
    task automatic test_spread_and_rotation();
        send_request(7'd1,  7'd2,  8'sd0);
        send_request(7'd3,  7'd8,  8'sd0);
        send_request(7'd5,  7'd8,  -8'sd1);
        send_request(7'd5,  7'd13, 8'sd3);
        send_request(7'd7,  7'd16, -8'sd128);
        send_request(7'd1,  7'd64, 8'sd127);
        send_request(7'd63, 7'd64, -8'sd128);
        send_request(7'd2,  7'd64, -8'sd65);
        send_request(7'd13, 7'd24, 8'sd100);
        send_request(7'd4,  7'd9,  8'sd64);
    endtask

    // Hold the receiver off while requests keep coming, so the output
    // register fills and the block stops taking requests
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        @(posedge i_clk);
        hold_requests++;
        @(negedge i_clk);
        repeat (12) begin
            send_random_request();
        end
        tx_idle_en = 1'b1;
    endtask

    // Back-to-back requests with the receiver always ready
    task automatic test_unthrottled_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (60) begin
            send_random_request();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Bulk random traffic with idling on both sides
    task automatic test_random_requests();
        repeat (350) begin
            send_random_request();
        end
    endtask

    initial begin
        mismatch_count   = 0;
        patterns_checked = 0;
        stall_cycles     = 0;
        hold_requests    = 0;
        tx_idle_en       = 1'b1;
        rx_idle_en       = 1'b1;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_pulses         = '0;
        i_steps          = '0;
        i_rotation       = '0;

        // Hold reset, then release it at a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_degenerate_requests();
        test_spread_and_rotation();
        test_output_backpressure();
        test_unthrottled_stream();
        test_random_requests();

        // Drop valid and drain everything still owed
        i_in_valid = 1'b0;
        while (expected_patterns.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: euclidean_rhythm_generator_unit.f
hw/rtl/erg_pkg.sv
hw/rtl/euclidean_rhythm_generator_unit.sv
bench/tb_euclidean_rhythm_generator_unit.sv
